@@ sv/tdrt_pkg.sv @@
// Shared types and codes for the task dependency release tracker.
// No dependencies; tdrt_ctrl and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package tdrt_pkg;

    localparam int unsigned PEND_W   = 7;
    localparam logic [6:0]  PEND_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_LOAD_NODE = 2'd0,
        OP_LOAD_EDGE = 2'd1,
        OP_START     = 2'd2,
        OP_COMPLETE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_NOT_REL   = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_RANGE     = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_LIST_FULL = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE_ID      = 2'd0,
        CFG_NODE_COUNT   = 2'd1,
        CFG_ARRIVE_STAMP = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_CHK,
        S_START_RD,
        S_START_CHK,
        S_CPL_LEN,
        S_CPL_CK_RD,
        S_CPL_CK,
        S_CPL_UP_RD,
        S_CPL_UP_S,
        S_CPL_UP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  node_index;
        logic [5:0]  dest_index;
        logic [7:0]  node_stage;
        logic        entry_mark;
        logic [31:0] done_task_id;
        logic [47:0] now_time;
    } t_in_beat;

    typedef struct packed {
        logic        task_valid;
        logic [31:0] ready_task_id;
        logic [7:0]  ready_stage;
        logic [47:0] ready_time;
        logic        last;
        logic [2:0]  status;
        logic        all_done;
    } t_out_beat;

    // Configuration as seen by the sequencer; nodes is already clamped.
    typedef struct packed {
        logic [31:0] base_id;
        logic [6:0]  nodes;
        logic [47:0] arrive_stamp;
    } t_cfg;

endpackage
`default_nettype wire

@@ sv/tdrt_ram.sv @@
// Simple dual-port RAM with registered read and read enable.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module tdrt_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/tdrt_ctrl.sv @@
// Sequencer of the tracker: flag vectors, node stores, result holdback and output register.
// Depends on tdrt_pkg and tdrt_ram.
`timescale 1ns / 1ps
`default_nettype none
module tdrt_ctrl #(
    parameter int unsigned MAX_NODES      = 64,
    parameter int unsigned MAX_SUCCESSORS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tdrt_pkg::t_cfg      i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tdrt_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tdrt_pkg::t_out_beat      o_out_data
);
    import tdrt_pkg::*;

    localparam int unsigned NW  = $clog2(MAX_NODES);
    localparam int unsigned LW  = $clog2(MAX_SUCCESSORS + 1);
    localparam int unsigned SD  = MAX_NODES * MAX_SUCCESSORS;
    localparam int unsigned SAW = $clog2(SD);
    localparam logic [SAW-1:0] MS_A = SAW'(MAX_SUCCESSORS);
    localparam logic [LW-1:0]  MS_L = LW'(MAX_SUCCESSORS);

    t_state r_state, n_state;

    logic [MAX_NODES-1:0] r_rel, r_cpl, r_entry, r_pend_vld, r_len_vld;
    logic [NW-1:0]  r_pend_ra, r_len_ra;
    logic [5:0]     r_a, r_b;
    logic [NW-1:0]  r_x, r_s;
    logic [47:0]    r_time;
    logic [LW-1:0]  r_j, r_len;
    logic [6:0]     r_idx;
    t_status        r_status;
    logic           r_hold_v;
    logic [31:0]    r_hold_id;
    logic [7:0]     r_hold_stage;
    logic [47:0]    r_hold_time;
    t_out_beat      r_out;
    logic           r_out_v;

    // next values
    logic [5:0]     n_a, n_b;
    logic [NW-1:0]  n_x, n_s;
    logic [47:0]    n_time;
    logic [LW-1:0]  n_j, n_len;
    logic [6:0]     n_idx;
    t_status        n_status;
    logic           n_hold_v;
    logic [31:0]    n_hold_id;
    logic [7:0]     n_hold_stage;
    logic [47:0]    n_hold_time;

    logic           push;
    t_out_beat      push_data;
    logic           set_rel, set_cpl, set_entry;
    logic [NW-1:0]  rel_idx, entry_idx;
    logic           entry_val;

    // RAM ports
    logic           st_we, st_re, sc_we, sc_re, pd_we, pd_re, ln_we, ln_re;
    logic [NW-1:0]  st_wa, st_ra, pd_wa, pd_ra, ln_wa, ln_ra;
    logic [SAW-1:0] sc_wa, sc_ra;
    logic [7:0]     st_wd, st_rd;
    logic [5:0]     sc_wd, sc_rd;
    logic [6:0]     pd_wd, pd_rd;
    logic [LW-1:0]  ln_wd, ln_rd;

    logic [6:0]     pend_val;
    logic [LW-1:0]  len_val;
    logic           slot_free, all_done, accept;
    logic [31:0]    x32;
    logic [32:0]    top_id;

    tdrt_ram #(.DEPTH(MAX_NODES), .WIDTH(8)) u_stage (
        .i_clk, .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_re(st_re), .i_raddr(st_ra), .o_rdata(st_rd));
    tdrt_ram #(.DEPTH(SD), .WIDTH(6)) u_succ (
        .i_clk, .i_we(sc_we), .i_waddr(sc_wa), .i_wdata(sc_wd),
        .i_re(sc_re), .i_raddr(sc_ra), .o_rdata(sc_rd));
    tdrt_ram #(.DEPTH(MAX_NODES), .WIDTH(PEND_W)) u_pend (
        .i_clk, .i_we(pd_we), .i_waddr(pd_wa), .i_wdata(pd_wd),
        .i_re(pd_re), .i_raddr(pd_ra), .o_rdata(pd_rd));
    tdrt_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_len (
        .i_clk, .i_we(ln_we), .i_waddr(ln_wa), .i_wdata(ln_wd),
        .i_re(ln_re), .i_raddr(ln_ra), .o_rdata(ln_rd));

    assign pend_val  = r_pend_vld[r_pend_ra] ? pd_rd : '0;
    assign len_val   = r_len_vld[r_len_ra] ? ln_rd : '0;
    assign slot_free = !r_out_v || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign x32    = i_in_data.done_task_id - i_cfg.base_id;
    assign top_id = {1'b0, i_cfg.base_id} + 33'(i_cfg.nodes) - 33'd1;

    always_comb begin
        all_done = 1'b1;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (!r_cpl[k] && (7'(k) < i_cfg.nodes)) all_done = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_a = r_a; n_b = r_b; n_x = r_x; n_s = r_s; n_time = r_time;
        n_j = r_j; n_len = r_len; n_idx = r_idx; n_status = r_status;
        n_hold_v = r_hold_v; n_hold_id = r_hold_id;
        n_hold_stage = r_hold_stage; n_hold_time = r_hold_time;
        push = 1'b0;
        push_data = '0;
        set_rel = 1'b0; rel_idx = '0;
        set_cpl = 1'b0;
        set_entry = 1'b0; entry_idx = '0; entry_val = 1'b0;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_re = 1'b0; st_ra = '0;
        sc_we = 1'b0; sc_wa = '0; sc_wd = '0; sc_re = 1'b0; sc_ra = '0;
        pd_we = 1'b0; pd_wa = '0; pd_wd = '0; pd_re = 1'b0; pd_ra = '0;
        ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_re = 1'b0; ln_ra = '0;
        // Move a held task to the output when a newer one displaces it.
        push_data.ready_task_id = r_hold_id;
        push_data.ready_stage   = r_hold_stage;
        push_data.ready_time    = r_hold_time;
        push_data.status        = ST_OK;
        push_data.all_done      = all_done;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a = i_in_data.node_index;
                    n_b = i_in_data.dest_index;
                    n_time = i_in_data.now_time;
                    n_hold_v = 1'b0;
                    case (i_in_data.opcode)
                        OP_LOAD_NODE: begin
                            if ({1'b0, i_in_data.node_index} >= i_cfg.nodes) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_status = ST_OK;
                                st_we = 1'b1;
                                st_wa = i_in_data.node_index[NW-1:0];
                                st_wd = i_in_data.node_stage;
                                set_entry = 1'b1;
                                entry_idx = i_in_data.node_index[NW-1:0];
                                entry_val = i_in_data.entry_mark;
                            end
                            n_state = S_FIN;
                        end
                        OP_LOAD_EDGE: begin
                            if ({1'b0, i_in_data.node_index} >= i_cfg.nodes ||
                                {1'b0, i_in_data.dest_index} >= i_cfg.nodes) begin
                                n_status = ST_RANGE;
                                n_state = S_FIN;
                            end else begin
                                ln_re = 1'b1;
                                ln_ra = i_in_data.node_index[NW-1:0];
                                pd_re = 1'b1;
                                pd_ra = i_in_data.dest_index[NW-1:0];
                                n_state = S_EDGE_CHK;
                            end
                        end
                        OP_START: begin
                            n_idx = '0;
                            n_status = ST_OK;
                            if (i_cfg.nodes == '0) begin
                                n_state = S_FIN;
                            end else if (top_id[32]) begin
                                n_status = ST_OVERFLOW;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_START_RD;
                            end
                        end
                        default: begin
                            n_x = x32[NW-1:0];
                            n_state = S_FIN;
                            if (i_in_data.done_task_id < i_cfg.base_id ||
                                x32 >= 32'(i_cfg.nodes)) begin
                                n_status = ST_UNKNOWN;
                            end else if (!r_rel[x32[NW-1:0]]) begin
                                n_status = ST_NOT_REL;
                            end else if (r_cpl[x32[NW-1:0]]) begin
                                n_status = ST_ALREADY;
                            end else begin
                                n_status = ST_OK;
                                ln_re = 1'b1;
                                ln_ra = x32[NW-1:0];
                                n_state = S_CPL_LEN;
                            end
                        end
                    endcase
                end
            end
            S_EDGE_CHK: begin
                n_state = S_FIN;
                if (len_val >= MS_L || pend_val >= PEND_MAX) begin
                    n_status = ST_LIST_FULL;
                end else begin
                    n_status = ST_OK;
                    sc_we = 1'b1;
                    sc_wa = SAW'(r_a[NW-1:0]) * MS_A + SAW'(len_val);
                    sc_wd = r_b;
                    ln_we = 1'b1;
                    ln_wa = r_a[NW-1:0];
                    ln_wd = len_val + LW'(1);
                    pd_we = 1'b1;
                    pd_wa = r_b[NW-1:0];
                    pd_wd = pend_val + 7'd1;
                end
            end
            S_START_RD: begin
                pd_re = 1'b1; pd_ra = r_idx[NW-1:0];
                st_re = 1'b1; st_ra = r_idx[NW-1:0];
                n_state = S_START_CHK;
            end
            S_START_CHK: begin
                if (r_entry[r_idx[NW-1:0]] && pend_val == '0 && !r_rel[r_idx[NW-1:0]]) begin
                    if (!r_hold_v || slot_free) begin
                        push = r_hold_v;
                        set_rel = 1'b1;
                        rel_idx = r_idx[NW-1:0];
                        n_hold_v = 1'b1;
                        n_hold_id = i_cfg.base_id + 32'(r_idx);
                        n_hold_stage = st_rd;
                        n_hold_time = i_cfg.arrive_stamp;
                        n_idx = r_idx + 7'd1;
                        n_state = (r_idx + 7'd1 == i_cfg.nodes) ? S_FIN : S_START_RD;
                    end
                end else begin
                    n_idx = r_idx + 7'd1;
                    n_state = (r_idx + 7'd1 == i_cfg.nodes) ? S_FIN : S_START_RD;
                end
            end
            S_CPL_LEN: begin
                n_len = len_val;
                n_j = '0;
                if (len_val == '0) begin
                    set_cpl = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_CPL_CK_RD;
                end
            end
            S_CPL_CK_RD: begin
                sc_re = 1'b1;
                sc_ra = SAW'(r_x) * MS_A + SAW'(r_j);
                n_state = S_CPL_CK;
            end
            S_CPL_CK: begin
                if ({1'b0, sc_rd} >= i_cfg.nodes) begin
                    n_status = ST_RANGE;
                    n_state = S_FIN;
                end else if (r_j + LW'(1) == r_len) begin
                    set_cpl = 1'b1;
                    n_j = '0;
                    n_state = S_CPL_UP_RD;
                end else begin
                    n_j = r_j + LW'(1);
                    n_state = S_CPL_CK_RD;
                end
            end
            S_CPL_UP_RD: begin
                sc_re = 1'b1;
                sc_ra = SAW'(r_x) * MS_A + SAW'(r_j);
                n_state = S_CPL_UP_S;
            end
            S_CPL_UP_S: begin
                n_s = sc_rd[NW-1:0];
                pd_re = 1'b1; pd_ra = sc_rd[NW-1:0];
                st_re = 1'b1; st_ra = sc_rd[NW-1:0];
                n_state = S_CPL_UP;
            end
            S_CPL_UP: begin
                if (!(r_cpl[r_s] == 1'b0 && pend_val == 7'd1 && !r_rel[r_s] &&
                      r_hold_v && !slot_free)) begin
                    if (!r_cpl[r_s] && pend_val != '0) begin
                        pd_we = 1'b1;
                        pd_wa = r_s;
                        pd_wd = pend_val - 7'd1;
                        if (pend_val == 7'd1 && !r_rel[r_s]) begin
                            push = r_hold_v;
                            set_rel = 1'b1;
                            rel_idx = r_s;
                            n_hold_v = 1'b1;
                            n_hold_id = i_cfg.base_id + 32'(r_s);
                            n_hold_stage = st_rd;
                            n_hold_time = r_time;
                        end
                    end
                    n_j = r_j + LW'(1);
                    n_state = (r_j + LW'(1) == r_len) ? S_FIN : S_CPL_UP_RD;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    push = 1'b1;
                    push_data.task_valid = r_hold_v;
                    if (!r_hold_v) begin
                        push_data.ready_task_id = '0;
                        push_data.ready_stage   = '0;
                        push_data.ready_time    = '0;
                    end
                    push_data.last   = 1'b1;
                    push_data.status = r_status;
                    n_hold_v = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (push && r_state != S_FIN) begin
            push_data.task_valid = 1'b1;
            push_data.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rel <= '0; r_cpl <= '0; r_entry <= '0;
            r_pend_vld <= '0; r_len_vld <= '0;
            r_hold_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            if (set_rel) r_rel[rel_idx] <= 1'b1;
            if (set_cpl) r_cpl[r_x] <= 1'b1;
            if (set_entry) r_entry[entry_idx] <= entry_val;
            if (pd_we) r_pend_vld[pd_wa] <= 1'b1;
            if (ln_we) r_len_vld[ln_wa] <= 1'b1;
            if (push) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_x <= n_x; r_s <= n_s; r_time <= n_time;
        r_j <= n_j; r_len <= n_len; r_idx <= n_idx; r_status <= n_status;
        r_hold_id <= n_hold_id; r_hold_stage <= n_hold_stage; r_hold_time <= n_hold_time;
        if (pd_re) r_pend_ra <= pd_ra;
        if (ln_re) r_len_ra <= ln_ra;
        if (push) r_out <= push_data;
    end
endmodule
`default_nettype wire

@@ sv/task_dependency_release_tracker.sv @@
// Top level of the task dependency release tracker: configuration registers and sequencer.
// Depends on tdrt_pkg, tdrt_ctrl and tdrt_ram.
`timescale 1ns / 1ps
`default_nettype none
// The tracker holds a task graph of up to MAX_NODES nodes, each with a count of
// unmet predecessors and a list of up to MAX_SUCCESSORS successors, and releases
// tasks as their predecessors complete. One input beat is taken at a time; in_ready
// stays low until its last result beat has entered the output register. Start scans
// every node in use, and for a completion a single sequencer walks the successor
// list once to check it and once to update counts, with a read and a write of the
// pending-count RAM per successor. Every input gives at least one result beat (a
// status-only beat with last set when nothing is released), and a full output
// register stalls the walk. Errors change no state. Memories need no clearing
// pass after reset: counts and list lengths carry per-node valid bits.
module task_dependency_release_tracker #(
    parameter int unsigned MAX_NODES      = 64,
    parameter int unsigned MAX_SUCCESSORS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tdrt_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tdrt_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [47:0]         i_cfg_wdata
);
    import tdrt_pkg::*;

    logic [31:0] r_base;
    logic [6:0]  r_node_count;
    logic [47:0] r_arrival;
    t_cfg        cfg;

    // Hold configuration; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_node_count <= '0;
            r_arrival <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_ID:      r_base <= i_cfg_wdata[31:0];
                CFG_NODE_COUNT:   r_node_count <= i_cfg_wdata[6:0];
                CFG_ARRIVE_STAMP: r_arrival <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A node count above the capacity acts as the capacity.
    always_comb begin
        cfg.base_id = r_base;
        cfg.arrive_stamp = r_arrival;
        cfg.nodes = (r_node_count > 7'(MAX_NODES)) ? 7'(MAX_NODES) : r_node_count;
    end

    tdrt_ctrl #(
        .MAX_NODES(MAX_NODES),
        .MAX_SUCCESSORS(MAX_SUCCESSORS)
    ) u_ctrl (
        .i_clk, .i_rst_n,
        .i_cfg(cfg),
        .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data
    );
endmodule
`default_nettype wire
